// ===== design/ghsa_pkg.sv =====
`default_nettype none

package ghsa_pkg;

	localparam int GEN_W = 32;

	typedef enum logic [1:0] {
		ACT_ALLOC   = 2'd0,
		ACT_RELEASE = 2'd1,
		ACT_QUERY   = 2'd2,
		ACT_SET     = 2'd3
	} action_t;

	typedef enum logic [1:0] {
		ERR_NONE   = 2'd0,
		ERR_HANDLE = 2'd1,
		ERR_FULL   = 2'd2
	} err_t;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_DECODE,
		ST_STACK,
		ST_SLOT
	} state_t;

	typedef struct packed {
		logic load;
		logic stack_rd;
		logic slot_rd_handle;
		logic slot_rd_stack;
		logic fresh;
		logic fail_full;
		logic fail_handle;
		logic exec;
	} ctrl_cmd_t;

	typedef struct packed {
		logic is_alloc;
		logic free_avail;
		logic fresh_avail;
		logic handle_pre_ok;
	} ctrl_sts_t;

endpackage

`default_nettype wire

// ===== design/generational_handle_slot_allocator.sv =====
`default_nettype none
// Generational handle slot allocator.
// Command channel: drive action, handle_index, handle_generation and
// enable_value with start; the transfer happens on a clock edge where start
// is high and busy is low. busy stays high while the command is worked on.
// Result channel: done pulses for one cycle with ok, error_code, out_index,
// out_generation, enabled_flag and the running totals; the result cannot be
// held off and must be taken in that cycle.
// Path from the accepting edge to done: the command is registered and
// decoded; allocate of a never-used slot, storage exhaustion, or a handle
// with a zero index, a zero generation or an index past the high-water mark
// are decided in DECODE; release, query, set-enable and a handle turned away
// for a dead slot or a stale generation are decided after a slot RAM read;
// allocate from the free stack reads the free-stack RAM and then the slot
// RAM. The next command can be accepted in the cycle done is shown.
// Reset: all slots read as dead, the free stack is empty and the counts are
// zero; slots past the high-water mark are never read, so no clearing pass
// is run and the block takes commands right after reset.
module generational_handle_slot_allocator #(
	parameter int SLOT_COUNT = 256
) (
	input  wire logic                             clk,
	input  wire logic                             arst_n,
	input  wire logic                             start,
	output logic                                  busy,
	input  wire logic [1:0]                       action,
	input  wire logic [$clog2(SLOT_COUNT+1)-1:0]  handle_index,
	input  wire logic [ghsa_pkg::GEN_W-1:0]       handle_generation,
	input  wire logic                             enable_value,
	output logic                                  done,
	output logic                                  ok,
	output logic [1:0]                            error_code,
	output logic [$clog2(SLOT_COUNT+1)-1:0]       out_index,
	output logic [ghsa_pkg::GEN_W-1:0]            out_generation,
	output logic                                  enabled_flag,
	output logic [$clog2(SLOT_COUNT+1)-1:0]       alive_total,
	output logic [$clog2(SLOT_COUNT+1)-1:0]       enabled_total
);

	import ghsa_pkg::*;

	ctrl_cmd_t cmd;
	ctrl_sts_t sts;

	ghsa_ctrl u_ctrl (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (start),
		.busy   (busy),
		.sts    (sts),
		.cmd    (cmd)
	);

	ghsa_dp #(
		.SLOT_COUNT (SLOT_COUNT)
	) u_dp (
		.clk               (clk),
		.arst_n            (arst_n),
		.cmd               (cmd),
		.sts               (sts),
		.action            (action),
		.handle_index      (handle_index),
		.handle_generation (handle_generation),
		.enable_value      (enable_value),
		.done              (done),
		.ok                (ok),
		.error_code        (error_code),
		.out_index         (out_index),
		.out_generation    (out_generation),
		.enabled_flag      (enabled_flag),
		.alive_total       (alive_total),
		.enabled_total     (enabled_total)
	);

	a_done_after_busy: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> $past(busy))
		else $error("result without a command in flight");

	a_enabled_le_alive: assert property (@(posedge clk) disable iff (!arst_n)
		enabled_total <= alive_total)
		else $error("enabled count exceeds alive count");

	a_ok_matches_err: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> (ok == (error_code == ERR_NONE)))
		else $error("ok and error code disagree");

	a_fail_zero_handle: assert property (@(posedge clk) disable iff (!arst_n)
		(done && !ok) |-> (out_index == '0 && out_generation == '0))
		else $error("failed command returned a handle");

	a_accept_busy: assert property (@(posedge clk) disable iff (!arst_n)
		(start && !busy) |=> busy)
		else $error("accepted command did not raise busy");

endmodule

`default_nettype wire

// ===== design/ghsa_ram.sv =====
`default_nettype none

module ghsa_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 256
) (
	input  wire logic                     clk,
	input  wire logic                     we,
	input  wire logic [$clog2(DEPTH)-1:0] waddr,
	input  wire logic [WIDTH-1:0]         wdata,
	input  wire logic [$clog2(DEPTH)-1:0] raddr,
	output logic      [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [WIDTH-1:0] rdata_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata_q <= mem_q[raddr];
	end

	assign rdata = rdata_q;

endmodule

`default_nettype wire

// ===== design/ghsa_ctrl.sv =====
`default_nettype none

module ghsa_ctrl (
	input  wire logic                 clk,
	input  wire logic                 arst_n,
	input  wire logic                 start,
	output logic                      busy,
	input  wire ghsa_pkg::ctrl_sts_t  sts,
	output ghsa_pkg::ctrl_cmd_t       cmd
);

	import ghsa_pkg::*;

	state_t state_q;
	state_t state_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d = state_q;
		cmd     = '0;
		busy    = 1'b1;
		unique case (state_q)
			ST_IDLE: begin
				busy = 1'b0;
				if (start) begin
					cmd.load = 1'b1;
					state_d  = ST_DECODE;
				end
			end
			ST_DECODE: begin
				if (sts.is_alloc) begin
					if (sts.free_avail) begin
						cmd.stack_rd = 1'b1;
						state_d      = ST_STACK;
					end else if (sts.fresh_avail) begin
						cmd.fresh = 1'b1;
						state_d   = ST_IDLE;
					end else begin
						cmd.fail_full = 1'b1;
						state_d       = ST_IDLE;
					end
				end else if (sts.handle_pre_ok) begin
					cmd.slot_rd_handle = 1'b1;
					state_d            = ST_SLOT;
				end else begin
					cmd.fail_handle = 1'b1;
					state_d         = ST_IDLE;
				end
			end
			ST_STACK: begin
				cmd.slot_rd_stack = 1'b1;
				state_d           = ST_SLOT;
			end
			ST_SLOT: begin
				cmd.exec = 1'b1;
				state_d  = ST_IDLE;
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

endmodule

`default_nettype wire

// ===== design/ghsa_dp.sv =====
`default_nettype none

module ghsa_dp #(
	parameter int SLOT_COUNT = 256
) (
	input  wire logic                                 clk,
	input  wire logic                                 arst_n,
	input  wire ghsa_pkg::ctrl_cmd_t                  cmd,
	output ghsa_pkg::ctrl_sts_t                       sts,
	input  wire logic [1:0]                           action,
	input  wire logic [$clog2(SLOT_COUNT+1)-1:0]      handle_index,
	input  wire logic [ghsa_pkg::GEN_W-1:0]           handle_generation,
	input  wire logic                                 enable_value,
	output logic                                      done,
	output logic                                      ok,
	output logic [1:0]                                error_code,
	output logic [$clog2(SLOT_COUNT+1)-1:0]           out_index,
	output logic [ghsa_pkg::GEN_W-1:0]                out_generation,
	output logic                                      enabled_flag,
	output logic [$clog2(SLOT_COUNT+1)-1:0]           alive_total,
	output logic [$clog2(SLOT_COUNT+1)-1:0]           enabled_total
);

	import ghsa_pkg::*;

	localparam int SW    = $clog2(SLOT_COUNT);
	localparam int CW    = $clog2(SLOT_COUNT + 1);
	localparam int ENT_W = GEN_W + 2;
	localparam logic [GEN_W-1:0] GEN_ONE = GEN_W'(1);
	localparam logic [CW-1:0]    CNT_MAX = CW'(SLOT_COUNT);

	action_t          action_q;
	logic [CW-1:0]    enc_q;
	logic [GEN_W-1:0] gen_q;
	logic             en_q;
	logic [SW-1:0]    slot_q;

	logic [CW-1:0] free_depth_q, free_depth_d;
	logic [CW-1:0] hw_q, hw_d;
	logic [CW-1:0] alive_q, alive_d;
	logic [CW-1:0] enab_q, enab_d;

	logic             done_q;
	logic             ok_q, ok_d;
	err_t             err_q, err_d;
	logic [CW-1:0]    oidx_q, oidx_d;
	logic [GEN_W-1:0] ogen_q, ogen_d;
	logic             oflag_q, oflag_d;
	logic             fin;

	logic [CW-1:0]    enc_m1;
	logic [SW-1:0]    stk_rdata;
	logic [SW-1:0]    stk_raddr;
	logic             stk_we;
	logic [ENT_W-1:0] slot_rdata;
	logic [SW-1:0]    slot_raddr;
	logic             slot_we;
	logic [SW-1:0]    slot_waddr;
	logic [ENT_W-1:0] slot_wdata;

	logic             rd_alive;
	logic             rd_en;
	logic [GEN_W-1:0] rd_gen;
	logic [GEN_W-1:0] gen_inc;

	assign enc_m1     = enc_q - CW'(1);
	assign stk_raddr  = SW'(free_depth_q - CW'(1));
	assign slot_raddr = cmd.slot_rd_stack ? stk_rdata : enc_m1[SW-1:0];
	assign rd_alive   = slot_rdata[GEN_W+1];
	assign rd_en      = slot_rdata[GEN_W];
	assign rd_gen     = slot_rdata[GEN_W-1:0];
	assign gen_inc    = (rd_gen + GEN_ONE == '0) ? GEN_ONE : rd_gen + GEN_ONE;

	assign sts.is_alloc      = (action_q == ACT_ALLOC);
	assign sts.free_avail    = (free_depth_q != '0);
	assign sts.fresh_avail   = (hw_q < CNT_MAX);
	assign sts.handle_pre_ok = (enc_q != '0) && (gen_q != '0) && (enc_m1 < hw_q);

	ghsa_ram #(
		.WIDTH (SW),
		.DEPTH (SLOT_COUNT)
	) u_stack_ram (
		.clk   (clk),
		.we    (stk_we),
		.waddr (free_depth_q[SW-1:0]),
		.wdata (slot_q),
		.raddr (stk_raddr),
		.rdata (stk_rdata)
	);

	ghsa_ram #(
		.WIDTH (ENT_W),
		.DEPTH (SLOT_COUNT)
	) u_slot_ram (
		.clk   (clk),
		.we    (slot_we),
		.waddr (slot_waddr),
		.wdata (slot_wdata),
		.raddr (slot_raddr),
		.rdata (slot_rdata)
	);

	always_comb begin
		slot_we      = 1'b0;
		slot_waddr   = slot_q;
		slot_wdata   = '0;
		stk_we       = 1'b0;
		free_depth_d = free_depth_q;
		hw_d         = hw_q;
		alive_d      = alive_q;
		enab_d       = enab_q;
		fin          = 1'b0;
		ok_d         = 1'b0;
		err_d        = ERR_NONE;
		oidx_d       = '0;
		ogen_d       = '0;
		oflag_d      = 1'b0;

		if (cmd.stack_rd) begin
			free_depth_d = free_depth_q - CW'(1);
		end

		if (cmd.fresh) begin
			slot_we    = 1'b1;
			slot_waddr = hw_q[SW-1:0];
			slot_wdata = {1'b1, en_q, GEN_ONE};
			hw_d       = hw_q + CW'(1);
			alive_d    = alive_q + CW'(1);
			enab_d     = enab_q + CW'(en_q);
			fin        = 1'b1;
			ok_d       = 1'b1;
			oidx_d     = hw_q + CW'(1);
			ogen_d     = GEN_ONE;
		end

		if (cmd.fail_full) begin
			fin   = 1'b1;
			err_d = ERR_FULL;
		end

		if (cmd.fail_handle) begin
			fin   = 1'b1;
			err_d = ERR_HANDLE;
		end

		if (cmd.exec) begin
			fin = 1'b1;
			if (action_q == ACT_ALLOC) begin
				slot_we    = 1'b1;
				slot_wdata = {1'b1, en_q, rd_gen};
				alive_d    = alive_q + CW'(1);
				enab_d     = enab_q + CW'(en_q);
				ok_d       = 1'b1;
				oidx_d     = CW'(slot_q) + CW'(1);
				ogen_d     = rd_gen;
			end else if (!rd_alive || rd_gen != gen_q) begin
				err_d = ERR_HANDLE;
			end else begin
				ok_d = 1'b1;
				unique case (action_q)
					ACT_RELEASE: begin
						slot_we    = 1'b1;
						slot_wdata = {1'b0, 1'b0, gen_inc};
						if (rd_en && enab_q != '0) begin
							enab_d = enab_q - CW'(1);
						end
						if (alive_q != '0) begin
							alive_d = alive_q - CW'(1);
						end
						if (free_depth_q < CNT_MAX) begin
							stk_we       = 1'b1;
							free_depth_d = free_depth_q + CW'(1);
						end
					end
					ACT_QUERY: begin
						oflag_d = rd_en;
					end
					ACT_SET: begin
						slot_we    = 1'b1;
						slot_wdata = {1'b1, en_q, rd_gen};
						if (en_q && !rd_en) begin
							enab_d = enab_q + CW'(1);
						end else if (!en_q && rd_en && enab_q != '0) begin
							enab_d = enab_q - CW'(1);
						end
					end
					default: begin
						err_d = ERR_HANDLE;
					end
				endcase
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			action_q <= action_t'(action);
			enc_q    <= handle_index;
			gen_q    <= handle_generation;
			en_q     <= enable_value;
		end
		if (cmd.slot_rd_handle) begin
			slot_q <= enc_m1[SW-1:0];
		end else if (cmd.slot_rd_stack) begin
			slot_q <= stk_rdata;
		end
		if (fin) begin
			ok_q    <= ok_d;
			err_q   <= err_d;
			oidx_q  <= oidx_d;
			ogen_q  <= ogen_d;
			oflag_q <= oflag_d;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			free_depth_q <= '0;
			hw_q         <= '0;
			alive_q      <= '0;
			enab_q       <= '0;
			done_q       <= 1'b0;
		end else begin
			free_depth_q <= free_depth_d;
			hw_q         <= hw_d;
			alive_q      <= alive_d;
			enab_q       <= enab_d;
			done_q       <= fin;
		end
	end

	assign done           = done_q;
	assign ok             = ok_q;
	assign error_code     = err_q;
	assign out_index      = oidx_q;
	assign out_generation = ogen_q;
	assign enabled_flag   = oflag_q;
	assign alive_total    = alive_q;
	assign enabled_total  = enab_q;

endmodule

`default_nettype wire
